@@ rtl/pim_pkg.sv @@
// Package for the PWM-input autorange meter: item, state and mode types,
// the prescaler range constants and the prescaler step function.
// No dependencies.
package pim_pkg;

   localparam int COUNT_FIELD_W = 16;
   localparam int PSC_W         = 16;
   localparam int TIME_W        = 17;

   typedef logic [1:0] mode_type;
   localparam mode_type MODE_IDLE  = 2'd0;
   localparam mode_type MODE_ARMED = 2'd1;
   localparam mode_type MODE_DONE  = 2'd2;

   localparam logic [PSC_W-1:0] PSC_DOUBLE_LIMIT = 16'h7FFF;
   localparam logic [PSC_W-1:0] PSC_MAX          = 16'hFFFF;
   localparam logic [PSC_W-1:0] PSC_FIRST        = 16'h0001;

   typedef struct packed {
      logic                     kind;
      logic                     overflow_flag;
      logic                     capture_flag;
      logic [COUNT_FIELD_W-1:0] high_count;
      logic [COUNT_FIELD_W-1:0] period_count;
   } item_type;

   typedef struct packed {
      mode_type           mode;
      logic [PSC_W-1:0]   prescale;
      logic               running;
   } ctrl_type;

   // autorange step: 0 -> 1, doubling while at most 0x7FFF, then saturate to 0xFFFF, then wrap to 0
   function automatic logic [PSC_W-1:0] next_prescale(input logic [PSC_W-1:0] p);
      logic [PSC_W-1:0] r;
      if (p == '0) begin
         r = PSC_FIRST;
      end else if (p == PSC_MAX) begin
         r = '0;
      end else if (p > PSC_DOUBLE_LIMIT) begin
         r = PSC_MAX;
      end else begin
         r = {p[PSC_W-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

@@ rtl/pwm_input_autorange_meter_core.sv @@
// Throughput: one item per cycle unless rsp_stall holds back a pending result.
// Items are registered at the input, then the update stage writes the
// mode, prescaler, run flag and held times, which double as the result register.
// Reset (synchronous): mode idle, prescaler 0, held times 0, counter running,
// both pipeline stages empty.
// Top level of the PWM-input autorange meter. Depends on pim_pkg, pim_step.
module pwm_input_autorange_meter_core #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_kind,
   input  logic                               req_overflow_flag,
   input  logic                               req_capture_flag,
   input  logic [pim_pkg::COUNT_FIELD_W-1:0]  req_high_count,
   input  logic [pim_pkg::COUNT_FIELD_W-1:0]  req_period_count,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_done_res,
   output logic [1:0]                         rsp_mode_now,
   output logic [pim_pkg::PSC_W-1:0]          rsp_prescale_now,
   output logic [pim_pkg::TIME_W-1:0]         rsp_high_time,
   output logic [pim_pkg::TIME_W-1:0]         rsp_cycle_time,
   output logic                               rsp_counter_clear,
   output logic                               rsp_timer_run
);
   import pim_pkg::*;

   localparam int CW = (COUNT_WIDTH < COUNT_FIELD_W) ? COUNT_WIDTH : COUNT_FIELD_W;
   localparam int HW = CW + 1;

   logic          in_valid_ff;
   item_type      item_ff;
   logic          out_valid_ff;
   ctrl_type      ctrl_ff;
   ctrl_type      ctrl_in;
   logic [HW-1:0] high_ff;
   logic [HW-1:0] high_in;
   logic [HW-1:0] cycle_ff;
   logic [HW-1:0] cycle_in;
   logic          clear_ff;
   logic          clear_in;
   logic          advance;
   logic          load;

   assign advance   = in_valid_ff && !(out_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign load      = req_valid && !req_stall;

   pim_step #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_step (
      .item      (item_ff),
      .ctrl_cur  (ctrl_ff),
      .high_cur  (high_ff),
      .cycle_cur (cycle_ff),
      .ctrl_nxt  (ctrl_in),
      .high_nxt  (high_in),
      .cycle_nxt (cycle_in),
      .clear_nxt (clear_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         ctrl_ff.mode     <= MODE_IDLE;
         ctrl_ff.prescale <= '0;
         ctrl_ff.running  <= 1'b1;
         high_ff          <= '0;
         cycle_ff         <= '0;
         clear_ff         <= 1'b0;
      end else begin
         if (load) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            ctrl_ff      <= ctrl_in;
            high_ff      <= high_in;
            cycle_ff     <= cycle_in;
            clear_ff     <= clear_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.kind          <= req_kind;
         item_ff.overflow_flag <= req_overflow_flag;
         item_ff.capture_flag  <= req_capture_flag;
         item_ff.high_count    <= req_high_count;
         item_ff.period_count  <= req_period_count;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_done_res      = ctrl_ff.mode == MODE_DONE;
   assign rsp_mode_now      = ctrl_ff.mode;
   assign rsp_prescale_now  = ctrl_ff.prescale;
   assign rsp_high_time     = TIME_W'(high_ff);
   assign rsp_cycle_time    = TIME_W'(cycle_ff);
   assign rsp_counter_clear = clear_ff;
   assign rsp_timer_run     = ctrl_ff.running;

endmodule

@@ rtl/pim_step.sv @@
// Next-state logic of the PWM-input autorange meter: one item against the
// current mode, prescaler, run flag and held times. Depends on pim_pkg.
module pim_step #(
   parameter int COUNT_WIDTH = 16
) (
   input  pim_pkg::item_type  item,
   input  pim_pkg::ctrl_type  ctrl_cur,
   input  logic [((COUNT_WIDTH < 16) ? COUNT_WIDTH : 16):0] high_cur,
   input  logic [((COUNT_WIDTH < 16) ? COUNT_WIDTH : 16):0] cycle_cur,
   output pim_pkg::ctrl_type  ctrl_nxt,
   output logic [((COUNT_WIDTH < 16) ? COUNT_WIDTH : 16):0] high_nxt,
   output logic [((COUNT_WIDTH < 16) ? COUNT_WIDTH : 16):0] cycle_nxt,
   output logic               clear_nxt
);
   import pim_pkg::*;

   localparam int CW = (COUNT_WIDTH < COUNT_FIELD_W) ? COUNT_WIDTH : COUNT_FIELD_W;
   localparam int HW = CW + 1;

   logic [HW-1:0] h_base;
   logic [HW-1:0] c_base;
   logic [HW-1:0] bump;
   logic          accept_meas;

   assign h_base      = {1'b0, item.high_count[CW-1:0]} + HW'(1);
   assign c_base      = {1'b0, item.period_count[CW-1:0]} + HW'(1);
   assign bump        = HW'(ctrl_cur.prescale == '0);
   assign accept_meas = h_base < c_base;

   always_comb begin
      ctrl_nxt  = ctrl_cur;
      high_nxt  = high_cur;
      cycle_nxt = cycle_cur;
      clear_nxt = 1'b0;
      if (item.kind) begin
         if (ctrl_cur.mode == MODE_DONE) begin
            ctrl_nxt.mode = MODE_IDLE;
         end
         ctrl_nxt.prescale = '0;
         ctrl_nxt.running  = 1'b1;
         clear_nxt         = 1'b1;
      end else if (ctrl_cur.mode == MODE_DONE) begin
         ctrl_nxt.prescale = '0;
         clear_nxt         = 1'b1;
      end else if (item.overflow_flag && !item.capture_flag) begin
         ctrl_nxt.mode     = MODE_IDLE;
         ctrl_nxt.prescale = next_prescale(ctrl_cur.prescale);
         clear_nxt         = 1'b1;
      end else if (ctrl_cur.mode != MODE_ARMED) begin
         if (item.capture_flag) begin
            ctrl_nxt.mode = MODE_ARMED;
         end
      end else if (item.capture_flag) begin
         if (accept_meas) begin
            ctrl_nxt.mode    = MODE_DONE;
            ctrl_nxt.running = 1'b0;
            high_nxt         = h_base + bump;
            cycle_nxt        = c_base + bump;
         end else begin
            ctrl_nxt.prescale = '0;
            ctrl_nxt.running  = 1'b1;
            clear_nxt         = 1'b1;
            high_nxt          = h_base;
            cycle_nxt         = c_base;
         end
      end
   end

endmodule

@@ dv/pwm_input_autorange_meter_checker.sv @@
// Checker for the PWM-input autorange meter: predicts every result from the
// accepted items and compares it with the result channel. Depends on pim_pkg.
module pwm_input_autorange_meter_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic                              req_kind,
   input  logic                              req_overflow_flag,
   input  logic                              req_capture_flag,
   input  logic [pim_pkg::COUNT_FIELD_W-1:0] req_high_count,
   input  logic [pim_pkg::COUNT_FIELD_W-1:0] req_period_count,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic                              rsp_done_res,
   input  logic [1:0]                        rsp_mode_now,
   input  logic [pim_pkg::PSC_W-1:0]         rsp_prescale_now,
   input  logic [pim_pkg::TIME_W-1:0]        rsp_high_time,
   input  logic [pim_pkg::TIME_W-1:0]        rsp_cycle_time,
   input  logic                              rsp_counter_clear,
   input  logic                              rsp_timer_run,
   output int                                fail_count,
   output int                                readings_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import pim_pkg::*;

   typedef struct packed {
      logic              done;
      mode_type          mode;
      logic [PSC_W-1:0]  prescale;
      logic [TIME_W-1:0] high;
      logic [TIME_W-1:0] cycle;
      logic              clear;
      logic              run;
   } reading_type;

   mode_type          mode_q;
   logic [PSC_W-1:0]  psc_q;
   logic [TIME_W-1:0] high_q;
   logic [TIME_W-1:0] cycle_q;
   logic              run_q;
   reading_type       readings[$];
   int                failures;
   int                result_no;

   function automatic logic [PSC_W-1:0] autorange_step(input logic [PSC_W-1:0] p);
      logic [PSC_W-1:0] r;
      if (p == '0) begin
         r = PSC_FIRST;
      end else if (p == PSC_MAX) begin
         r = '0;
      end else if (p > PSC_DOUBLE_LIMIT) begin
         r = PSC_MAX;
      end else begin
         r = p << 1;
      end
      return r;
   endfunction

   function automatic reading_type meter_update(input item_type it);
      reading_type       r;
      logic [TIME_W-1:0] h;
      logic [TIME_W-1:0] c;
      r.clear = 1'b0;
      if (it.kind) begin
         if (mode_q == MODE_DONE) mode_q = MODE_IDLE;
         psc_q   = '0;
         run_q   = 1'b1;
         r.clear = 1'b1;
      end else if (mode_q == MODE_DONE) begin
         psc_q   = '0;
         r.clear = 1'b1;
      end else if (it.overflow_flag && !it.capture_flag) begin
         mode_q  = MODE_IDLE;
         psc_q   = autorange_step(psc_q);
         r.clear = 1'b1;
      end else if (mode_q != MODE_ARMED) begin
         if (it.capture_flag) mode_q = MODE_ARMED;
      end else if (it.capture_flag) begin
         h = TIME_W'(it.high_count) + 1'b1;
         c = TIME_W'(it.period_count) + 1'b1;
         if (h < c) begin
            mode_q = MODE_DONE;
            if (psc_q == '0) begin
               h = h + 1'b1;
               c = c + 1'b1;
            end
            run_q = 1'b0;
         end else begin
            psc_q   = '0;
            run_q   = 1'b1;
            r.clear = 1'b1;
         end
         high_q  = h;
         cycle_q = c;
      end
      r.done     = (mode_q == MODE_DONE);
      r.mode     = mode_q;
      r.prescale = psc_q;
      r.high     = high_q;
      r.cycle    = cycle_q;
      r.run      = run_q;
      return r;
   endfunction

   always @(posedge clock) begin
      reading_type want;
      reading_type got;
      item_type    it;
      if (reset) begin
         mode_q  = MODE_IDLE;
         psc_q   = '0;
         high_q  = '0;
         cycle_q = '0;
         run_q   = 1'b1;
         readings.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_done_res, rsp_mode_now, rsp_prescale_now, rsp_high_time,
                    rsp_cycle_time, rsp_counter_clear, rsp_timer_run};
            if (readings.size() == 0) begin
               if (failures < 10)
                  $display("checker: result %0d arrived with nothing predicted",
                           result_no);
               failures++;
            end else begin
               want = readings.pop_front();
               if (got.done !== want.done || got.mode !== want.mode ||
                   got.prescale !== want.prescale || got.high !== want.high ||
                   got.cycle !== want.cycle || got.clear !== want.clear ||
                   got.run !== want.run) begin
                  if (failures < 10) begin
                     $display("checker: result %0d mismatch", result_no);
                     $display({"  expected done=%0d mode=%0d psc=%h high=%h",
                               " cycle=%h clr=%0d run=%0d"},
                              want.done, want.mode, want.prescale, want.high, want.cycle,
                              want.clear, want.run);
                     $display({"  actual   done=%0d mode=%0d psc=%h high=%h",
                               " cycle=%h clr=%0d run=%0d"},
                              got.done, got.mode, got.prescale, got.high, got.cycle,
                              got.clear, got.run);
                  end
                  failures++;
               end
            end
            result_no++;
         end
         if (req_valid && !req_stall) begin
            it = '{req_kind, req_overflow_flag, req_capture_flag,
                   req_high_count, req_period_count};
            readings.push_back(meter_update(it));
         end
      end
      fail_count       <= failures;
      readings_pending <= readings.size();
   end

endmodule

@@ dv/pwm_input_autorange_meter_core_tb.sv @@
// Testbench top for pwm_input_autorange_meter_core: directed and random interrupt
// and restart items with random idling on both channels. Depends on pim_pkg,
// the core RTL and pwm_input_autorange_meter_checker.
module pwm_input_autorange_meter_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pim_pkg::*;

   logic                     clock             = 1'b0;
   logic                     reset             = 1'b1;
   logic                     req_valid         = 1'b0;
   logic                     req_stall;
   logic                     req_kind          = 1'b0;
   logic                     req_overflow_flag = 1'b0;
   logic                     req_capture_flag  = 1'b0;
   logic [COUNT_FIELD_W-1:0] req_high_count    = '0;
   logic [COUNT_FIELD_W-1:0] req_period_count  = '0;
   logic                     rsp_valid;
   logic                     rsp_stall         = 1'b0;
   logic                     rsp_done_res;
   logic [1:0]               rsp_mode_now;
   logic [PSC_W-1:0]         rsp_prescale_now;
   logic [TIME_W-1:0]        rsp_high_time;
   logic [TIME_W-1:0]        rsp_cycle_time;
   logic                     rsp_counter_clear;
   logic                     rsp_timer_run;
   int                       fail_count;
   int                       readings_pending;
   int                       cyc = 0;
   int                       items_sent = 0;

   pwm_input_autorange_meter_core dut (.*);
   pwm_input_autorange_meter_checker checker_i (.*);

   always #5ns clock = ~clock;

   always @(posedge clock) cyc <= cyc + 1;

   function automatic bit calm_window();
      return cyc >= 1700 && cyc < 2200;
   endfunction

   always @(posedge clock) begin
      int rsp_cycles;
      int hold_left;
      rsp_cycles++;
      if (rsp_cycles == 1000) hold_left = 300;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (calm_window()) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 36);
      end
   end

   function automatic item_type make_item(input bit k, input bit o, input bit c,
                                          input logic [15:0] h, input logic [15:0] p);
      item_type it;
      it.kind          = k;
      it.overflow_flag = o;
      it.capture_flag  = c;
      it.high_count    = h;
      it.period_count  = p;
      return it;
   endfunction

   function automatic logic [15:0] rnd16();
      return 16'($urandom);
   endfunction

   function automatic bit rnd1();
      return 1'($urandom_range(1));
   endfunction

   task automatic push_item(input item_type it);
      while (!calm_window() && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_kind          <= it.kind;
      req_overflow_flag <= it.overflow_flag;
      req_capture_flag  <= it.capture_flag;
      req_high_count    <= it.high_count;
      req_period_count  <= it.period_count;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // overflows, arm, measure, done interrupts, restart
   task automatic measure_burst();
      int               n_ovf;
      int               r;
      logic [15:0]      hc;
      logic [15:0]      pc;
      n_ovf = ($urandom_range(99) < 15) ? $urandom_range(20, 14) : $urandom_range(3);
      repeat (n_ovf) push_item(make_item(0, 1, 0, rnd16(), rnd16()));
      push_item(make_item(0, rnd1(), 1, rnd16(), rnd16()));
      if ($urandom_range(3) == 0) push_item(make_item(0, 0, 0, rnd16(), rnd16()));
      r = $urandom_range(99);
      if (r < 5) begin
         pc = 16'hFFFF;
         hc = rnd1() ? 16'hFFFE : 16'h0000;
      end else if (r < 80) begin
         pc = rnd16();
         hc = (pc == 0) ? 16'h0 : 16'($urandom_range(pc - 1));
      end else begin
         hc = rnd16();
         pc = 16'($urandom_range(hc));
      end
      push_item(make_item(0, rnd1(), 1, hc, pc));
      repeat ($urandom_range(2))
         push_item(make_item(0, rnd1(), rnd1(), rnd16(), rnd16()));
      if ($urandom_range(9) != 0)
         push_item(make_item(1, rnd1(), rnd1(), rnd16(), rnd16()));
   endtask

   task automatic noise_burst();
      repeat ($urandom_range(4, 1))
         push_item(make_item($urandom_range(99) < 20, rnd1(), rnd1(), rnd16(), rnd16()));
   endtask

   initial begin
      int n;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      push_item(make_item(0, 0, 0, 16'h0000, 16'h0000));
      push_item(make_item(0, 0, 1, 16'h1234, 16'h5678));
      push_item(make_item(0, 0, 1, 16'h0000, 16'hFFFF));
      push_item(make_item(0, 1, 1, 16'hFFFF, 16'hFFFF));
      push_item(make_item(1, 1, 1, 16'hFFFF, 16'h0000));
      push_item(make_item(0, 1, 0, 16'hAAAA, 16'h5555));
      push_item(make_item(0, 1, 0, 16'h5555, 16'hAAAA));
      push_item(make_item(0, 1, 1, 16'h0001, 16'h0002));
      push_item(make_item(0, 0, 1, 16'hFFFF, 16'hFFFF));
      push_item(make_item(0, 0, 1, 16'hFFFE, 16'hFFFF));
      push_item(make_item(1, 0, 0, 16'h0000, 16'h0000));
      push_item(make_item(0, 1, 0, 16'h0000, 16'h0000));
      push_item(make_item(0, 1, 0, 16'h0000, 16'h0000));
      push_item(make_item(0, 1, 0, 16'h0000, 16'h0000));
      push_item(make_item(0, 0, 1, 16'h0000, 16'h0000));
      push_item(make_item(1, 0, 1, 16'h0010, 16'h0020));
      push_item(make_item(0, 1, 0, 16'h0000, 16'h0000));
      push_item(make_item(0, 0, 1, 16'h0000, 16'h0000));
      push_item(make_item(0, 1, 1, 16'h000A, 16'h0014));
      push_item(make_item(1, 0, 0, 16'h0000, 16'h0000));
      push_item(make_item(0, 0, 1, 16'h0000, 16'h0000));
      push_item(make_item(0, 0, 1, 16'h0005, 16'h0005));
      push_item(make_item(0, 0, 1, 16'h0000, 16'h0000));
      push_item(make_item(0, 0, 1, 16'h0000, 16'h0001));
      push_item(make_item(1, 0, 0, 16'h0000, 16'h0000));

      while (items_sent < 900) begin
         if ($urandom_range(99) < 80) measure_burst();
         else noise_burst();
      end
      req_valid <= 1'b0;

      for (n = 0; n < 5000 && readings_pending != 0; n++) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && readings_pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("tb: failure");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/pim_pkg.sv
rtl/pim_step.sv
rtl/pwm_input_autorange_meter_core.sv
dv/pwm_input_autorange_meter_checker.sv
dv/pwm_input_autorange_meter_core_tb.sv
